/* rtl/tts_pkg.sv */
// Shared types and constants of the text terminal cursor and scroll logic.
// Used by the controller, the datapath and the top level; no dependencies.
package tts_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 30;

	localparam logic [2:0] FN_PUT    = 3'd0;
	localparam logic [2:0] FN_SETCUR = 3'd1;
	localparam logic [2:0] FN_WRITE  = 3'd2;
	localparam logic [2:0] FN_SCROLL = 3'd3;
	localparam logic [2:0] FN_CLEAR  = 3'd4;

	localparam logic [1:0] ACT_STATUS = 2'd0;
	localparam logic [1:0] ACT_WRITE  = 2'd1;
	localparam logic [1:0] ACT_CLRROW = 2'd2;
	localparam logic [1:0] ACT_CLRALL = 2'd3;

	localparam logic [7:0] CH_NL = 8'd10;
	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_BS = 8'd8;
	localparam logic [7:0] CH_SP = 8'd32;

	typedef struct packed {
		logic load;   // latch the input item
		logic step;   // produce one result and update cursor/base
		logic first;  // the step is the first one of the item
	} tts_cmd_t;

endpackage

/* rtl/tts_ctrl.sv */
// Sequencer of the text terminal: input handshake, result steps, output valid.
// Depends on tts_pkg; drives the datapath through tts_cmd_t.
module tts_ctrl
	import tts_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  logic     step_last,
	output tts_cmd_t cmd
);

	typedef enum logic [1:0] {
		IDLE,
		RUN_FIRST,
		RUN_NEXT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == IDLE);
	assign out_valid = out_valid_q;
	// a result slot opens when the output register is empty or being taken
	assign out_free  = !out_valid_q || out_ready;

	assign cmd.load  = in_valid && (state_q == IDLE);
	assign cmd.step  = (state_q != IDLE) && out_free;
	assign cmd.first = (state_q == RUN_FIRST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_valid) state_q <= RUN_FIRST;
				end
				RUN_FIRST, RUN_NEXT: begin
					if (cmd.step) state_q <= step_last ? IDLE : RUN_NEXT;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

/* rtl/tts_dp.sv */
// Datapath of the text terminal: latched item, cursor and base registers,
// row-ring address arithmetic and the result register. Depends on tts_pkg.
module tts_dp
	import tts_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  tts_cmd_t   cmd,
	input  logic [2:0] func,
	input  logic [7:0] char_code,
	input  logic [6:0] col,
	input  logic [5:0] row,
	input  logic [5:0] scroll_count,
	output logic       step_last,
	output logic [1:0]  action,
	output logic [11:0] cell_index,
	output logic [7:0]  cell_char,
	output logic [4:0]  clear_row,
	output logic [6:0]  cursor_col,
	output logic [4:0]  cursor_row,
	output logic [4:0]  base_row,
	output logic        last
);

	localparam int CW = $clog2(COLUMNS);
	localparam int RW = $clog2(ROWS);
	localparam int IW = $clog2(ROWS * COLUMNS);

	logic [2:0] func_q;
	logic [7:0] char_q;
	logic [6:0] col_q;
	logic [5:0] row_q;
	logic [5:0] scnt_q;
	logic [5:0] cnt_q;

	logic [CW-1:0] cur_col_q;
	logic [RW-1:0] cur_row_q;
	logic [RW-1:0] top_q;

	logic [CW-1:0] nxt_col;
	logic [RW-1:0] nxt_row;
	logic [RW-1:0] nxt_top;
	logic [5:0]    nxt_cnt;
	logic [1:0]    act;
	logic [7:0]    wchar;
	logic [RW-1:0] lrow;
	logic [CW-1:0] ccol;
	logic [RW-1:0] top_adv;
	logic [RW:0]   psum;
	logic [RW-1:0] prow;
	logic [IW-1:0] idx;
	logic          in_range;

	assign top_adv  = (top_q == RW'(ROWS - 1)) ? '0 : top_q + 1'b1;
	assign in_range = ({1'b0, col_q} < 8'(COLUMNS)) && ({1'b0, row_q} < 7'(ROWS));

	// logical to physical row on the ring, then linear cell address
	assign psum = {1'b0, top_q} + {1'b0, lrow};
	assign prow = (psum >= (RW+1)'(ROWS)) ? RW'(psum - (RW+1)'(ROWS)) : psum[RW-1:0];
	assign idx  = IW'(prow) * IW'(COLUMNS) + IW'(ccol);

	always_comb begin
		act       = ACT_STATUS;
		wchar     = '0;
		nxt_col   = cur_col_q;
		nxt_row   = cur_row_q;
		nxt_top   = top_q;
		nxt_cnt   = cnt_q;
		step_last = 1'b1;
		lrow      = cur_row_q;
		ccol      = cur_col_q;
		if (!cmd.first) begin
			// one more scrolled row: the new bottom row is the old top row
			act       = ACT_CLRROW;
			nxt_top   = top_adv;
			if (func_q == FN_SCROLL && cur_row_q != '0) nxt_row = cur_row_q - 1'b1;
			nxt_cnt   = cnt_q - 6'd1;
			step_last = (cnt_q == 6'd1);
		end else begin
			unique case (func_q)
				FN_PUT: begin
					priority if (char_q == CH_NL) begin
						nxt_col = '0;
						if (cur_row_q != RW'(ROWS - 1)) begin
							nxt_row = cur_row_q + 1'b1;
						end else begin
							act     = ACT_CLRROW;
							nxt_top = top_adv;
						end
					end else if (char_q == CH_CR) begin
						nxt_col = '0;
					end else if (char_q == CH_BS) begin
						if (cur_col_q != '0) begin
							act     = ACT_WRITE;
							wchar   = CH_SP;
							ccol    = cur_col_q - 1'b1;
							nxt_col = ccol;
						end else if (cur_row_q != '0) begin
							act     = ACT_WRITE;
							wchar   = CH_SP;
							lrow    = cur_row_q - 1'b1;
							ccol    = CW'(COLUMNS - 1);
							nxt_row = lrow;
							nxt_col = ccol;
						end
					end else begin
						act   = ACT_WRITE;
						wchar = char_q;
						if (cur_col_q != CW'(COLUMNS - 1)) begin
							nxt_col = cur_col_q + 1'b1;
						end else begin
							nxt_col = '0;
							if (cur_row_q != RW'(ROWS - 1)) begin
								nxt_row = cur_row_q + 1'b1;
							end else begin
								// wrap on the last row: scroll once after the write
								nxt_cnt   = 6'd1;
								step_last = 1'b0;
							end
						end
					end
				end
				FN_SETCUR: begin
					if (in_range) begin
						nxt_col = CW'(col_q);
						nxt_row = RW'(row_q);
					end
				end
				FN_WRITE: begin
					if (in_range) begin
						act   = ACT_WRITE;
						wchar = char_q;
						lrow  = RW'(row_q);
						ccol  = CW'(col_q);
					end
				end
				FN_SCROLL: begin
					if (scnt_q != '0) begin
						act     = ACT_CLRROW;
						nxt_top = top_adv;
						if (cur_row_q != '0) nxt_row = cur_row_q - 1'b1;
						nxt_cnt   = scnt_q - 6'd1;
						step_last = (scnt_q == 6'd1);
					end
				end
				FN_CLEAR: begin
					act     = ACT_CLRALL;
					nxt_col = '0;
					nxt_row = '0;
					nxt_top = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
			top_q     <= '0;
		end else if (cmd.step) begin
			cur_col_q <= nxt_col;
			cur_row_q <= nxt_row;
			top_q     <= nxt_top;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			char_q <= char_code;
			col_q  <= col;
			row_q  <= row;
			scnt_q <= scroll_count;
		end
		if (cmd.step) begin
			cnt_q      <= nxt_cnt;
			action     <= act;
			cell_index <= (act == ACT_WRITE) ? 12'(idx) : '0;
			cell_char  <= wchar;
			clear_row  <= (act == ACT_CLRROW) ? 5'(top_q) : '0;
			cursor_col <= 7'(nxt_col);
			cursor_row <= 5'(nxt_row);
			base_row   <= 5'(nxt_top);
			last       <= step_last;
		end
	end

endmodule

/* rtl/text_terminal_cursor_scroll.sv */
// Text terminal control: takes one operation per item (put char, set cursor,
// write at cell, scroll up, clear screen) and emits one result per memory
// effect, each with cursor and base row as status. An item is latched when
// it is taken, and its results are then loaded into the output register one
// per cycle while the output side keeps up; the next item is accepted while
// the last result of the previous one still waits in the output register.
// Rows of the character memory form a ring; cell_index is physical row times
// COLUMNS plus column. Depends on tts_pkg, tts_ctrl and tts_dp.
module text_terminal_cursor_scroll
	import tts_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [7:0]  char_code,
	input  logic [6:0]  col,
	input  logic [5:0]  row,
	input  logic [5:0]  scroll_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  action,
	output logic [11:0] cell_index,
	output logic [7:0]  cell_char,
	output logic [4:0]  clear_row,
	output logic [6:0]  cursor_col,
	output logic [4:0]  cursor_row,
	output logic [4:0]  base_row,
	output logic        last
);

	tts_cmd_t cmd;
	logic     step_last;

	tts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.step_last (step_last),
		.cmd       (cmd)
	);

	tts_dp #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.func         (func),
		.char_code    (char_code),
		.col          (col),
		.row          (row),
		.scroll_count (scroll_count),
		.step_last    (step_last),
		.action       (action),
		.cell_index   (cell_index),
		.cell_char    (cell_char),
		.clear_row    (clear_row),
		.cursor_col   (cursor_col),
		.cursor_row   (cursor_row),
		.base_row     (base_row),
		.last         (last)
	);

endmodule

/* test/tb.sv */
// Testbench for text_terminal_cursor_scroll: directed and random operations with a
// cycle-free model of cursor, base row and memory effects, checked result by result.
// Depends on tts_pkg and the top level of the block.
`timescale 1ns / 100ps

module tb;
	import tts_pkg::*;

	localparam int NCOL        = COLUMNS_DEF;
	localparam int NROW        = ROWS_DEF;
	localparam int IDLE_LIMIT  = 1000;
	localparam int DRAIN_WAIT  = 20;
	localparam int RANDOM_OPS  = 300;
	localparam int REPORT_MAX  = 10;

	typedef struct packed {
		logic [1:0]  action;
		logic [11:0] cell_index;
		logic [7:0]  cell_char;
		logic [4:0]  clear_row;
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic [4:0]  base_row;
		logic        last;
	} term_effect_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  func;
	logic [7:0]  char_code;
	logic [6:0]  col;
	logic [5:0]  row;
	logic [5:0]  scroll_count;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  action;
	logic [11:0] cell_index;
	logic [7:0]  cell_char;
	logic [4:0]  clear_row;
	logic [6:0]  cursor_col;
	logic [4:0]  cursor_row;
	logic [4:0]  base_row;
	logic        last;

	// terminal state as predicted
	int cur_x;
	int cur_y;
	int top_y;

	term_effect_t expected_effects[$];
	term_effect_t item_effects[$];
	int           fail_count = 0;
	int           idle_cycles = 0;
	bit           no_gaps;

	text_terminal_cursor_scroll uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.char_code    (char_code),
		.col          (col),
		.row          (row),
		.scroll_count (scroll_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.action       (action),
		.cell_index   (cell_index),
		.cell_char    (cell_char),
		.clear_row    (clear_row),
		.cursor_col   (cursor_col),
		.cursor_row   (cursor_row),
		.base_row     (base_row),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int draw_gap();
		if (no_gaps)
			return 0;
		return $urandom_range(0, 9);
	endfunction

	function automatic int phys_row(int logical);
		int p;
		p = top_y + logical;
		if (p >= NROW)
			p -= NROW;
		return p;
	endfunction

	function automatic void bump_base();
		top_y = (top_y + 1 >= NROW) ? 0 : top_y + 1;
	endfunction

	function automatic void note_effect(logic [1:0] act, int idx, logic [7:0] ch, int crow);
		term_effect_t e;
		e.action     = act;
		e.cell_index = idx[11:0];
		e.cell_char  = ch;
		e.clear_row  = crow[4:0];
		e.cursor_col = cur_x[6:0];
		e.cursor_row = cur_y[4:0];
		e.base_row   = top_y[4:0];
		e.last       = 1'b0;
		item_effects.push_back(e);
	endfunction

	// Work out the memory effects of one operation and queue them in order.
	function automatic void predict_terminal_effects(logic [2:0] f, logic [7:0] ch,
			logic [6:0] c, logic [5:0] r, logic [5:0] n);
		int idx;
		item_effects.delete();
		case (f)
			FN_PUT: begin
				if (ch == CH_NL) begin
					cur_x = 0;
					if (cur_y + 1 < NROW) begin
						cur_y++;
						note_effect(ACT_STATUS, 0, 8'd0, 0);
					end else begin
						bump_base();
						note_effect(ACT_CLRROW, 0, 8'd0, phys_row(NROW - 1));
					end
				end else if (ch == CH_CR) begin
					cur_x = 0;
					note_effect(ACT_STATUS, 0, 8'd0, 0);
				end else if (ch == CH_BS) begin
					if (cur_x != 0 || cur_y != 0) begin
						if (cur_x != 0) begin
							cur_x--;
						end else begin
							cur_y--;
							cur_x = NCOL - 1;
						end
						note_effect(ACT_WRITE, phys_row(cur_y) * NCOL + cur_x, CH_SP, 0);
					end else begin
						note_effect(ACT_STATUS, 0, 8'd0, 0);
					end
				end else begin
					idx = phys_row(cur_y) * NCOL + cur_x;
					cur_x++;
					if (cur_x < NCOL) begin
						note_effect(ACT_WRITE, idx, ch, 0);
					end else begin
						cur_x = 0;
						if (cur_y + 1 < NROW) begin
							cur_y++;
							note_effect(ACT_WRITE, idx, ch, 0);
						end else begin
							// wrap on the last row: write first, then scroll
							note_effect(ACT_WRITE, idx, ch, 0);
							bump_base();
							note_effect(ACT_CLRROW, 0, 8'd0, phys_row(NROW - 1));
						end
					end
				end
			end
			FN_SETCUR: begin
				if (c < NCOL && r < NROW) begin
					cur_x = int'(c);
					cur_y = int'(r);
				end
				note_effect(ACT_STATUS, 0, 8'd0, 0);
			end
			FN_WRITE: begin
				if (c < NCOL && r < NROW)
					note_effect(ACT_WRITE, phys_row(int'(r)) * NCOL + int'(c), ch, 0);
				else
					note_effect(ACT_STATUS, 0, 8'd0, 0);
			end
			FN_SCROLL: begin
				if (n == 0) begin
					note_effect(ACT_STATUS, 0, 8'd0, 0);
				end else begin
					for (int k = 0; k < n; k++) begin
						bump_base();
						if (cur_y != 0)
							cur_y--;
						note_effect(ACT_CLRROW, 0, 8'd0, phys_row(NROW - 1));
					end
				end
			end
			FN_CLEAR: begin
				top_y = 0;
				cur_x = 0;
				cur_y = 0;
				note_effect(ACT_CLRALL, 0, 8'd0, 0);
			end
			default: note_effect(ACT_STATUS, 0, 8'd0, 0);
		endcase
		item_effects[item_effects.size() - 1].last = 1'b1;
		foreach (item_effects[i])
			expected_effects.push_back(item_effects[i]);
	endfunction

	// Present one item after a random gap and hold it until accepted.
	task automatic send_op(input logic [2:0] f, input logic [7:0] ch, input logic [6:0] c,
			input logic [5:0] r, input logic [5:0] n);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		func         <= f;
		char_code    <= ch;
		col          <= c;
		row          <= r;
		scroll_count <= n;
		do @(posedge clk); while (!in_ready);
		predict_terminal_effects(f, ch, c, r, n);
	endtask

	task automatic put_char(input logic [7:0] ch);
		send_op(FN_PUT, ch, 7'($urandom), 6'($urandom), 6'($urandom));
	endtask

	task automatic set_cursor(input logic [6:0] c, input logic [5:0] r);
		send_op(FN_SETCUR, 8'($urandom), c, r, 6'($urandom));
	endtask

	task automatic test_printable_wrap();
		put_char(8'h41);
		put_char(8'h00);
		put_char(8'hFF);
		set_cursor(7'(NCOL - 1), 6'd0);
		put_char(8'h5A);
		set_cursor(7'(NCOL - 1), 6'(NROW - 1));
		put_char(8'h7E);
	endtask

	task automatic test_control_chars();
		set_cursor(7'd5, 6'd3);
		put_char(CH_NL);
		set_cursor(7'd0, 6'(NROW - 1));
		put_char(CH_NL);
		put_char(CH_CR);
		put_char(CH_BS);
		put_char(CH_BS);
		set_cursor(7'd0, 6'd0);
		put_char(CH_BS);
	endtask

	task automatic test_cursor_and_cell();
		set_cursor(7'(NCOL), 6'd5);
		set_cursor(7'd127, 6'd63);
		set_cursor(7'd10, 6'(NROW));
		send_op(FN_WRITE, 8'hA5, 7'(NCOL - 1), 6'(NROW - 1), 6'($urandom));
		send_op(FN_WRITE, 8'h5A, 7'd0, 6'd0, 6'($urandom));
		send_op(FN_WRITE, 8'h33, 7'd127, 6'd63, 6'($urandom));
		send_op(3'd5, 8'($urandom), 7'($urandom), 6'($urandom), 6'($urandom));
		send_op(3'd7, 8'($urandom), 7'($urandom), 6'($urandom), 6'($urandom));
	endtask

	task automatic test_scroll_and_clear();
		send_op(FN_SCROLL, 8'($urandom), 7'($urandom), 6'($urandom), 6'd0);
		send_op(FN_SCROLL, 8'($urandom), 7'($urandom), 6'($urandom), 6'd1);
		send_op(FN_SCROLL, 8'($urandom), 7'($urandom), 6'($urandom), 6'd63);
		send_op(FN_CLEAR, 8'($urandom), 7'($urandom), 6'($urandom), 6'($urandom));
	endtask

	task automatic test_random_ops();
		int          pick;
		logic [2:0]  f;
		logic [7:0]  ch;
		logic [6:0]  c;
		logic [5:0]  r;
		logic [5:0]  n;
		for (int i = 0; i < RANDOM_OPS; i++) begin
			if (i % 25 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			ch   = 8'($urandom);
			c    = 7'($urandom);
			r    = 6'($urandom);
			n    = 6'($urandom);
			if (pick < 55) begin
				f = FN_PUT;
				case ($urandom_range(0, 9))
					0: ch = CH_NL;
					1: ch = CH_CR;
					2: ch = CH_BS;
					default: ;
				endcase
			end else if (pick < 70) begin
				f = FN_SETCUR;
				// often steer toward the right edge and bottom rows
				if ($urandom_range(0, 9) < 7) begin
					c = 7'($urandom_range(0, 2) == 0 ? $urandom_range(0, NCOL - 1)
						: NCOL - 1 - $urandom_range(0, 1));
					r = 6'($urandom_range(0, 2) == 0 ? $urandom_range(0, NROW - 1)
						: NROW - 1 - $urandom_range(0, 1));
				end
			end else if (pick < 80) begin
				f = FN_WRITE;
			end else if (pick < 88) begin
				f = FN_SCROLL;
				if ($urandom_range(0, 9) != 0)
					n = 6'($urandom_range(0, 4));
			end else if (pick < 91) begin
				f = FN_CLEAR;
			end else if (pick < 95) begin
				f = 3'($urandom_range(5, 7));
			end else begin
				f = 3'($urandom);
			end
			send_op(f, ch, c, r, n);
		end
		no_gaps = 1'b0;
	endtask

	// output side: stall a random number of cycles before each result
	initial begin
		int gap;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin : check_effects
		term_effect_t got;
		term_effect_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{action, cell_index, cell_char, clear_row, cursor_col, cursor_row,
				base_row, last};
			if (expected_effects.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("unexpected result: act=%0d idx=%0d ch=%0d crow=%0d",
						got.action, got.cell_index, got.cell_char, got.clear_row,
						" cur=(%0d,%0d) base=%0d last=%0b",
						got.cursor_col, got.cursor_row, got.base_row, got.last);
			end else begin
				want = expected_effects.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("mismatch: exp act=%0d idx=%0d ch=%0d crow=%0d",
							want.action, want.cell_index, want.cell_char,
							want.clear_row,
							" cur=(%0d,%0d) base=%0d last=%0b",
							want.cursor_col, want.cursor_row, want.base_row,
							want.last,
							" | got act=%0d idx=%0d ch=%0d crow=%0d",
							got.action, got.cell_index, got.cell_char,
							got.clear_row,
							" cur=(%0d,%0d) base=%0d last=%0b",
							got.cursor_col, got.cursor_row, got.base_row,
							got.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		func         = '0;
		char_code    = '0;
		col          = '0;
		row          = '0;
		scroll_count = '0;
		cur_x        = 0;
		cur_y        = 0;
		top_y        = 0;
		no_gaps      = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_printable_wrap();
		test_control_chars();
		test_cursor_and_cell();
		test_scroll_and_clear();
		test_random_ops();
		in_valid <= 1'b0;

		while (expected_effects.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0 && expected_effects.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
